// ===== rtl/core/qbs_pkg.sv =====
// qbs_pkg: shared types and constants of the quad batch setup unit.
// Command codes, result kinds, unit UVs and the controller/datapath structs.
// No dependencies.
package qbs_pkg;

  typedef enum logic [1:0] {
    CMD_QUAD_UNIT = 2'd0,
    CMD_QUAD_UV   = 2'd1,
    CMD_FLUSH     = 2'd2,
    CMD_NONE      = 2'd3
  } qbs_op_t;

  localparam logic KIND_FLUSH  = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  localparam int TEX_SLOT_W = 4;
  localparam int BATCH_W    = 11;

  // Unit UVs for BL, BR, TL, TR
  localparam logic [31:0] UNIT_UV [4] = '{
    32'h0000_0000, 32'h8000_0000, 32'h0000_8000, 32'h8000_8000
  };

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        tex_handle;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        quad_width;
    logic [30:0]        quad_height;
    logic [31:0]        rgba;
    logic [3:0][31:0]   uv_corner;
  } qbs_item_t;

  typedef struct packed {
    logic                  kind;
    logic signed [31:0]    vx;
    logic signed [31:0]    vy;
    logic signed [31:0]    vz;
    logic [31:0]           vuv;
    logic [31:0]           vcolor;
    logic [TEX_SLOT_W-1:0] tex_slot;
    logic [BATCH_W-1:0]    batch_quads;
    logic                  last;
  } qbs_result_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch;
    logic       prep;
    logic       alloc;
    logic       load_flush;
    logic       flush_last;
    logic       load_vert;
    logic [1:0] vert_idx;
  } qbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    qbs_op_t held_op;
    logic    full;
    logic    out_free;
  } qbs_stat_t;

endpackage

// ===== rtl/core/qbs_in_if.sv =====
// qbs_in_if: request channel of the quad batch setup unit.
// Valid/ready handshake with the quad or flush request payload. No dependencies.
interface qbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [31:0]        tex_handle;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic [30:0]        quad_width;
  logic [30:0]        quad_height;
  logic [31:0]        rgba;
  logic [31:0]        uv_corner0;
  logic [31:0]        uv_corner1;
  logic [31:0]        uv_corner2;
  logic [31:0]        uv_corner3;

  modport source (
    output valid, cmd, tex_handle, cx, cy, cz, quad_width, quad_height, rgba,
           uv_corner0, uv_corner1, uv_corner2, uv_corner3,
    input  ready
  );
  modport sink (
    input  valid, cmd, tex_handle, cx, cy, cz, quad_width, quad_height, rgba,
           uv_corner0, uv_corner1, uv_corner2, uv_corner3,
    output ready
  );
endinterface

// ===== rtl/core/qbs_out_if.sv =====
// qbs_out_if: result channel of the quad batch setup unit.
// Valid/ready handshake with a vertex record or flush event. No dependencies.
interface qbs_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] vx;
  logic signed [31:0] vy;
  logic signed [31:0] vz;
  logic [31:0]        vuv;
  logic [31:0]        vcolor;
  logic [3:0]         tex_slot;
  logic [10:0]        batch_quads;
  logic               last;

  modport source (
    output valid, kind, vx, vy, vz, vuv, vcolor, tex_slot, batch_quads, last,
    input  ready
  );
  modport sink (
    input  valid, kind, vx, vy, vz, vuv, vcolor, tex_slot, batch_quads, last,
    output ready
  );
endinterface

// ===== rtl/core/quad_batch_setup_unit.sv =====
// quad_batch_setup_unit: top level; joins controller and datapath to the channels.
// Depends on qbs_pkg, qbs_in_if, qbs_out_if, qbs_ctrl and qbs_dp.
//
//   channel   dir   handshake            moves
//   in_chan   in    valid/ready (sink)   quad or flush request
//   out_chan  out   valid/ready (source) vertex record or flush event
//
// A quad request runs through the controller sequence: setup, a flush first
// when the batch is full, slot allocation, then one result register load per
// vertex; a flush request loads one flush event and an unused command is dropped.
// The last vertex waits in the result register while the next request is
// accepted. Output stalls hold the sequence in place.
// Reset is synchronous, active low: quad counter clears, slot counter goes to 1,
// slot table entries are left unwritten and are never read before being written.
module quad_batch_setup_unit import qbs_pkg::*; #(
  parameter int QUAD_CAPACITY = 1024,
  parameter int TEXTURE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  qbs_in_if.sink      in_chan,
  qbs_out_if.source   out_chan
);

  qbs_item_t   item;
  qbs_cmd_t    ctl_cmd;
  qbs_stat_t   dp_stat;
  qbs_result_t res;
  logic        in_ready;
  logic        out_valid;

  // Pack the request payload
  always_comb begin
    item.cmd          = in_chan.cmd;
    item.tex_handle   = in_chan.tex_handle;
    item.cx           = in_chan.cx;
    item.cy           = in_chan.cy;
    item.cz           = in_chan.cz;
    item.quad_width   = in_chan.quad_width;
    item.quad_height  = in_chan.quad_height;
    item.rgba         = in_chan.rgba;
    item.uv_corner[0] = in_chan.uv_corner0;
    item.uv_corner[1] = in_chan.uv_corner1;
    item.uv_corner[2] = in_chan.uv_corner2;
    item.uv_corner[3] = in_chan.uv_corner3;
  end

  qbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_cmd   (in_chan.cmd),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .ctl      (ctl_cmd)
  );

  qbs_dp #(
    .QUAD_CAPACITY (QUAD_CAPACITY),
    .TEXTURE_SLOTS (TEXTURE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (item),
    .ctl       (ctl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_res   (res),
    .out_ready (out_chan.ready)
  );

  // Drive the channels
  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid;
  assign out_chan.kind        = res.kind;
  assign out_chan.vx          = res.vx;
  assign out_chan.vy          = res.vy;
  assign out_chan.vz          = res.vz;
  assign out_chan.vuv         = res.vuv;
  assign out_chan.vcolor      = res.vcolor;
  assign out_chan.tex_slot    = res.tex_slot;
  assign out_chan.batch_quads = res.batch_quads;
  assign out_chan.last        = res.last;

  // No result load while a new request can be taken
  a_ready_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !(ctl_cmd.load_flush || ctl_cmd.load_vert))
    else $error("result load while accepting a request");

  // An unused command leaves the block ready in the next cycle
  a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.cmd == CMD_NONE)) |=> in_chan.ready)
    else $error("unused command not dropped");

  // A vertex record carries no batch count
  a_vert_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.kind == KIND_VERTEX)) |-> (out_chan.batch_quads == '0))
    else $error("vertex record with nonzero batch count");

  // A flush event carries no slot and no position
  a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.kind == KIND_FLUSH)) |->
      ((out_chan.tex_slot == '0) && (out_chan.vx == '0) && (out_chan.vuv == '0)))
    else $error("flush event with vertex data");

endmodule

// ===== rtl/core/qbs_dp.sv =====
// qbs_dp: datapath of the quad batch setup unit: held request, corner math,
// batch counters, texture slot table and the result register. Uses qbs_pkg.
module qbs_dp import qbs_pkg::*; #(
  parameter int QUAD_CAPACITY = 1024,
  parameter int TEXTURE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  qbs_item_t   in_item,
  input  qbs_cmd_t    ctl,
  output qbs_stat_t   stat,
  output logic        out_valid,
  output qbs_result_t out_res,
  input  logic        out_ready
);

  localparam int QCW = $clog2(QUAD_CAPACITY + 1);
  localparam int SCW = $clog2(TEXTURE_SLOTS + 1);
  localparam int SIW = $clog2(TEXTURE_SLOTS);

  qbs_item_t          item_r;
  logic [QCW-1:0]     quad_count_r;
  logic [SCW-1:0]     slot_count_r;
  logic [31:0]        handles_r [TEXTURE_SLOTS];
  logic [TEXTURE_SLOTS-1:0] hits_r, hits_nxt;
  logic signed [31:0] xs_r [2];
  logic signed [31:0] ys_r [2];
  logic signed [31:0] xs_nxt [2];
  logic signed [31:0] ys_nxt [2];
  logic [SIW-1:0]     slot_r, slot_nxt, found_idx;
  logic               found;
  logic               out_valid_r;
  qbs_result_t        res_r;
  logic signed [32:0] cx_w, cy_w, hw_w, hh_w;

  // Clamp a 33-bit sum to the signed 32-bit range
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Status back to the controller
  assign stat.held_op  = qbs_op_t'(item_r.cmd);
  assign stat.full     = (quad_count_r >= QCW'(QUAD_CAPACITY)) ||
                         (slot_count_r >= SCW'(TEXTURE_SLOTS));
  assign stat.out_free = !out_valid_r || out_ready;

  // Corner coordinates from centre and half size
  always_comb begin
    cx_w = {item_r.cx[31], item_r.cx};
    cy_w = {item_r.cy[31], item_r.cy};
    hw_w = {3'b000, item_r.quad_width[30:1]};
    hh_w = {3'b000, item_r.quad_height[30:1]};
    xs_nxt[0] = sat33(cx_w - hw_w);
    xs_nxt[1] = sat33(cx_w + hw_w);
    ys_nxt[0] = sat33(cy_w - hh_w);
    ys_nxt[1] = sat33(cy_w + hh_w);
  end

  // Compare the handle against every table entry
  always_comb begin
    for (int i = 0; i < TEXTURE_SLOTS; i++) begin
      hits_nxt[i] = (handles_r[i] == item_r.tex_handle);
    end
  end

  // Lowest live matching slot; slot 0 for handle 0, next free slot on a miss
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = TEXTURE_SLOTS - 1; i >= 1; i--) begin
      if (hits_r[i] && (SCW'(i) < slot_count_r)) begin
        found     = 1'b1;
        found_idx = SIW'(i);
      end
    end
    if (item_r.tex_handle == 32'd0) begin
      slot_nxt = '0;
    end else if (found) begin
      slot_nxt = found_idx;
    end else begin
      slot_nxt = slot_count_r[SIW-1:0];
    end
  end

  // Hold the request and the per-quad intermediates
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item_r <= in_item;
    end
    if (ctl.prep) begin
      hits_r <= hits_nxt;
      xs_r   <= xs_nxt;
      ys_r   <= ys_nxt;
    end
    if (ctl.alloc) begin
      slot_r <= slot_nxt;
    end
  end

  // Store a new handle on a table miss
  always_ff @(posedge clk) begin
    if (ctl.alloc && (item_r.tex_handle != 32'd0) && !found) begin
      handles_r[slot_count_r[SIW-1:0]] <= item_r.tex_handle;
    end
  end

  // Counters: reset on flush, quads count allocations, slots count misses
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_count_r <= '0;
      slot_count_r <= SCW'(1);
    end else if (ctl.load_flush) begin
      quad_count_r <= '0;
      slot_count_r <= SCW'(1);
    end else if (ctl.alloc) begin
      quad_count_r <= quad_count_r + QCW'(1);
      if ((item_r.tex_handle != 32'd0) && !found) begin
        slot_count_r <= slot_count_r + SCW'(1);
      end
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_flush || ctl.load_vert) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (ctl.load_flush) begin
      res_r.kind        <= KIND_FLUSH;
      res_r.vx          <= '0;
      res_r.vy          <= '0;
      res_r.vz          <= '0;
      res_r.vuv         <= '0;
      res_r.vcolor      <= '0;
      res_r.tex_slot    <= '0;
      res_r.batch_quads <= BATCH_W'(quad_count_r);
      res_r.last        <= ctl.flush_last;
    end else if (ctl.load_vert) begin
      res_r.kind        <= KIND_VERTEX;
      res_r.vx          <= xs_r[ctl.vert_idx[0]];
      res_r.vy          <= ys_r[ctl.vert_idx[1]];
      res_r.vz          <= item_r.cz;
      res_r.vuv         <= (qbs_op_t'(item_r.cmd) == CMD_QUAD_UV) ?
                           item_r.uv_corner[ctl.vert_idx] : UNIT_UV[ctl.vert_idx];
      res_r.vcolor      <= item_r.rgba;
      res_r.tex_slot    <= TEX_SLOT_W'(slot_r);
      res_r.batch_quads <= '0;
      res_r.last        <= (ctl.vert_idx == 2'd3);
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/core/qbs_ctrl.sv =====
// qbs_ctrl: controller state machine of the quad batch setup unit.
// Sequences accept, setup, flush, slot allocation and four vertices. Uses qbs_pkg.
module qbs_ctrl import qbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_cmd,
  output logic      in_ready,
  input  qbs_stat_t stat,
  output qbs_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_FLUSH,
    S_ALLOC,
    S_VERT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] vcnt_r, vcnt_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    vcnt_nxt  = vcnt_r;
    ctl       = '0;
    in_ready  = (state_r == S_IDLE);
    ctl.vert_idx = vcnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          case (qbs_op_t'(in_cmd))
            CMD_FLUSH:                 state_nxt = S_FLUSH;
            CMD_QUAD_UNIT, CMD_QUAD_UV: state_nxt = S_PREP;
            default:                   state_nxt = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        ctl.prep  = 1'b1;
        state_nxt = stat.full ? S_FLUSH : S_ALLOC;
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          ctl.load_flush = 1'b1;
          ctl.flush_last = (stat.held_op == CMD_FLUSH);
          state_nxt      = ctl.flush_last ? S_IDLE : S_ALLOC;
        end
      end
      S_ALLOC: begin
        ctl.alloc = 1'b1;
        vcnt_nxt  = 2'd0;
        state_nxt = S_VERT;
      end
      S_VERT: begin
        if (stat.out_free) begin
          ctl.load_vert = 1'b1;
          vcnt_nxt      = vcnt_r + 2'd1;
          if (vcnt_r == 2'd3) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and vertex counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

endmodule
